>>> hw/rtl/obkt_pkg.sv
package obkt_pkg;

	// Table size and the cap on words per dump
	localparam int DEPTH_DEF = 16;
	localparam int OUT_LIMIT = 16;

	localparam int KEY_W   = 16;
	localparam int PRICE_W = 32;
	localparam int QTY_W   = 24;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_MODIFY = 2'd1,
		OP_DELETE = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_APPLIED   = 3'd0,
		STAT_INVALID   = 3'd1,
		STAT_DUPLICATE = 3'd2,
		STAT_NOTFOUND  = 3'd3,
		STAT_FULL      = 3'd4,
		STAT_DUMP      = 3'd5,
		STAT_EMPTY     = 3'd6
	} status_t;

	// What every cell of the row does this cycle
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_MODIFY,
		CMD_DELETE,
		CMD_ROTATE
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   quantity;
	} entry_t;

	// Broadcast from the controller to the whole row
	typedef struct packed {
		cmd_t   cmd;
		entry_t data;
	} cell_ctl_t;

endpackage

>>> hw/rtl/obkt_cell.sv
module obkt_cell import obkt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [CW-1:0] count,
	input  entry_t        nb_entry,   // entry of the next cell up
	input  entry_t        head_entry, // entry of cell 0, for the wrap
	input  logic          found_in,
	output logic          found_out,
	output entry_t        entry
);

	entry_t entry_q;
	logic   occupied;
	logic   match;
	logic   at_count;
	logic   at_top;

	assign occupied  = CW'(IDX) < count;
	assign match     = occupied && (entry_q.key == ctl.data.key);
	assign found_out = found_in | match;
	assign at_count  = CW'(IDX) == count;
	assign at_top    = CW'(IDX + 1) == count;
	assign entry     = entry_q;

	// Payload only, no reset
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (at_count) entry_q <= ctl.data;
			end
			CMD_MODIFY: begin
				if (match) begin
					entry_q.price    <= ctl.data.price;
					entry_q.quantity <= ctl.data.quantity;
				end
			end
			CMD_DELETE: begin
				// close the gap from the matching cell upwards
				if (occupied && found_out) entry_q <= nb_entry;
			end
			CMD_ROTATE: begin
				if (at_top) entry_q <= head_entry;
				else if (occupied) entry_q <= nb_entry;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/order_book_keyed_table.sv
// Channel  Direction  Signals
// in       input      in_valid, in_ready, operation, position_key, price, quantity
// out      output     out_valid, out_ready, status, entry_key, entry_price,
//                     entry_quantity, last
//
// An update captures the word; once the output register is free, the row of
// cells compares keys in parallel and applies the change, giving one status word.
// A dump captures the word, then the row rotates one place per cycle and cell 0 is
// emitted, up to OUT_LIMIT words; a word due at a full output holds the row.
// Reset clears the entry count and control only; entry contents are not cleared.
// A full output register stalls the row; a new word is taken while a result waits.
module order_book_keyed_table import obkt_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [KEY_W-1:0]   position_key,
	input  logic [PRICE_W-1:0] price,
	input  logic [QTY_W-1:0]   quantity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [KEY_W-1:0]   entry_key,
	output logic [PRICE_W-1:0] entry_price,
	output logic [QTY_W-1:0]   entry_quantity,
	output logic               last
);

	state_t  state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] step_q, step_d;
	logic [CW-1:0] dump_n;
	op_t     op_q;
	entry_t  req_q;

	logic    out_valid_q, out_valid_d;
	logic    load_out;
	status_t status_q, status_d;
	entry_t  res_q, res_d;
	logic    last_q, last_d;

	cell_ctl_t ctl;
	entry_t    ents [DEPTH];
	logic      found [DEPTH+1];
	logic      slot_free;
	logic      found_any;
	logic      invalid;
	logic      emitting;

	// Row of cells, match flag rippling from cell 0 upwards
	assign found[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t nb;
		if (i == DEPTH - 1) begin : g_top
			assign nb = ents[i];
		end else begin : g_mid
			assign nb = ents[i+1];
		end
		obkt_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.nb_entry   (nb),
			.head_entry (ents[0]),
			.found_in   (found[i]),
			.found_out  (found[i+1]),
			.entry      (ents[i])
		);
	end

	assign found_any = found[DEPTH];
	assign slot_free = !out_valid_q || out_ready;
	assign invalid   = (req_q.price == '0) || (req_q.quantity == '0);
	assign dump_n    = (32'(count_q) > OUT_LIMIT) ? CW'(OUT_LIMIT) : count_q;
	assign emitting  = step_q < dump_n;

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Captured request and result words
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q           <= op_t'(operation);
			req_q.key      <= position_key;
			req_q.price    <= price;
			req_q.quantity <= quantity;
		end
		if (load_out) begin
			status_q <= status_d;
			res_q    <= res_d;
			last_q   <= last_d;
		end
	end

	// Next state, row command and result
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		step_d   = step_q;
		ctl.cmd  = CMD_HOLD;
		ctl.data = req_q;
		load_out = 1'b0;
		status_d = STAT_APPLIED;
		res_d    = '{key: req_q.key, price: '0, quantity: '0};
		last_d   = 1'b1;
		in_ready = (state_q == S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_DUMP) begin
					if (count_q == '0) begin
						if (slot_free) begin
							load_out = 1'b1;
							status_d = STAT_EMPTY;
							state_d  = S_IDLE;
						end
					end else begin
						step_d  = '0;
						state_d = S_DUMP;
					end
				end else if (slot_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					if (invalid) begin
						status_d = STAT_INVALID;
					end else begin
						case (op_q)
							OP_INSERT: begin
								if (found_any) status_d = STAT_DUPLICATE;
								else if (count_q >= CW'(DEPTH)) status_d = STAT_FULL;
								else begin
									ctl.cmd = CMD_INSERT;
									count_d = count_q + CW'(1);
								end
							end
							OP_MODIFY: begin
								if (!found_any) status_d = STAT_NOTFOUND;
								else ctl.cmd = CMD_MODIFY;
							end
							default: begin
								if (!found_any) status_d = STAT_NOTFOUND;
								else begin
									ctl.cmd = CMD_DELETE;
									count_d = count_q - CW'(1);
								end
							end
						endcase
					end
				end
			end
			S_DUMP: begin
				// rotate once per step; emit cell 0 while under the cap
				if (!emitting || slot_free) begin
					ctl.cmd = CMD_ROTATE;
					if (emitting) begin
						load_out = 1'b1;
						status_d = STAT_DUMP;
						res_d    = ents[0];
						last_d   = (step_q + CW'(1)) == dump_n;
					end
					step_d = step_q + CW'(1);
					if ((step_q + CW'(1)) == count_q) state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (load_out) out_valid_d = 1'b1;
		else if (out_ready) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_key      = res_q.key;
	assign entry_price    = res_q.price;
	assign entry_quantity = res_q.quantity;
	assign last           = last_q;

endmodule
